FILE: rtl/core/bll_pkg.sv
package bll_pkg;

   localparam int CAPACITY_DEFAULT   = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int COMMAND_BITS = 3;
   localparam int DATA_BITS    = 32;
   localparam int POS_BITS     = 7;
   localparam int STATUS_BITS  = 3;

   typedef logic [COMMAND_BITS-1:0]     command_type;
   typedef logic signed [DATA_BITS-1:0] data_type;
   typedef logic [POS_BITS-1:0]         position_type;
   typedef logic [STATUS_BITS-1:0]      status_type;

   localparam command_type CMD_PUSH_FRONT = 3'd0;
   localparam command_type CMD_PUSH_BACK  = 3'd1;
   localparam command_type CMD_POP_FRONT  = 3'd2;
   localparam command_type CMD_POP_BACK   = 3'd3;
   localparam command_type CMD_INSERT_AT  = 3'd4;
   localparam command_type CMD_SEARCH     = 3'd5;
   localparam command_type CMD_LENGTH     = 3'd6;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_EMPTY    = 3'd1;
   localparam status_type ST_FULL     = 3'd2;
   localparam status_type ST_BAD_POS  = 3'd3;
   localparam status_type ST_NOTFOUND = 3'd4;

endpackage

FILE: rtl/core/bll_req_if.sv
interface bll_req_if
   import bll_pkg::*;
();
   logic         valid;
   logic         ready;
   command_type  command;
   data_type     value;
   position_type position;

   modport source (output valid, output command, output value, output position, input ready);
   modport sink   (input valid, input command, input value, input position, output ready);
endinterface

FILE: rtl/core/bll_rsp_if.sv
interface bll_rsp_if
   import bll_pkg::*;
();
   logic         valid;
   logic         ready;
   status_type   status;
   position_type found_position;
   position_type length;

   modport source (output valid, output status, output found_position, output length,
                   input ready);
   modport sink   (input valid, input status, input found_position, input length,
                   output ready);
endinterface

FILE: rtl/core/bounded_linked_list_engine_unit.sv
// channel   dir  handshake          payload
// req_ch    in   valid/ready        command, value, position
// rsp_ch    out  valid/ready        status, found_position, length
//
// Length, any error status and a pop of the only entry by pop back respond after decide.
// Push front, pop front and a push back onto an empty list add an allocate or pop step.
// Search walks the links one node per cycle through the node memory read port:
// it stops at a match or at the last node. Pop back walks to the node before the tail
// and insert inside the list to the node before position; both, and push back, then link.
// Reset (synchronous) empties the list; node memory is not cleared.
// A result waiting on rsp_ch holds only the final step; req_ch is ready in idle.
module bounded_linked_list_engine_unit
   import bll_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bll_req_if.sink    req_ch,
   bll_rsp_if.source  rsp_ch
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
   localparam int MW = (CW > POS_BITS) ? CW : POS_BITS;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_ALLOC  = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_POPF   = 3'd4;
   localparam logic [2:0] S_LINK   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [IW-1:0] rhead_ff, rhead_in;
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   command_type   cmd_ff, cmd_in;
   logic [SW-1:0] val_ff, val_in;
   position_type  pos_ff, pos_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] node_ff, node_in;
   logic [IW-1:0] lnk_ff, lnk_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] target_ff, target_in;
   status_type    status_ff, status_in;
   position_type  found_ff, found_in;
   status_type    rsp_status_ff, rsp_status_in;
   position_type  rsp_found_ff, rsp_found_in;
   position_type  rsp_length_ff, rsp_length_in;

   logic          wr_val_en, wr_link_en;
   logic [IW-1:0] wr_addr, wr_link, rd_addr, rd_link;
   logic [SW-1:0] rd_val;

   logic          full, is_front, is_back, rsp_load, walk_end;
   logic [IW-1:0] alloc_node;

   bll_ram #(.DEPTH(CAPACITY), .WIDTH(SW), .ADDR_BITS(IW)) u_values (
      .clock   (clock),
      .wr_en   (wr_val_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_val)
   );

   bll_ram #(.DEPTH(CAPACITY), .WIDTH(IW), .ADDR_BITS(IW)) u_links (
      .clock   (clock),
      .wr_en   (wr_link_en),
      .wr_addr (wr_addr),
      .wr_data (wr_link),
      .rd_addr (rd_addr),
      .rd_data (rd_link)
   );

   assign full       = (len_ff == CW'(CAPACITY));
   assign is_front   = (cmd_ff == CMD_PUSH_FRONT) ||
                       ((cmd_ff == CMD_INSERT_AT) && (pos_ff == '0));
   assign is_back    = (cmd_ff == CMD_PUSH_BACK) ||
                       ((cmd_ff == CMD_INSERT_AT) && (MW'(pos_ff) == MW'(len_ff)));
   assign alloc_node = (rcnt_ff != '0) ? rhead_ff : IW'(fresh_ff);
   assign walk_end   = (k_ff == target_ff);
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.found_position = rsp_found_ff;
   assign rsp_ch.length         = rsp_length_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      len_in        = len_ff;
      fresh_in      = fresh_ff;
      rhead_in      = rhead_ff;
      rcnt_in       = rcnt_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      node_in       = node_ff;
      lnk_in        = lnk_ff;
      k_in          = k_ff;
      target_in     = target_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      wr_val_en     = 1'b0;
      wr_link_en    = 1'b0;
      wr_addr       = node_ff;
      wr_link       = '0;
      rd_addr       = head_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      rsp_valid_in  = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in    = req_ch.command;
               val_in    = req_ch.value[SW-1:0];
               pos_in    = req_ch.position;
               status_in = ST_OK;
               found_in  = '0;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            case (cmd_ff)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     rd_addr  = rhead_ff;
                     state_in = S_ALLOC;
                  end
               end
               CMD_INSERT_AT: begin
                  if (MW'(pos_ff) > MW'(len_ff)) begin
                     status_in = ST_BAD_POS;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     rd_addr  = rhead_ff;
                     state_in = S_ALLOC;
                  end
               end
               CMD_POP_FRONT: begin
                  if (len_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     state_in = S_POPF;
                  end
               end
               CMD_POP_BACK: begin
                  if (len_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (len_ff == CW'(1)) begin
                     wr_link_en = 1'b1;
                     wr_addr    = tail_ff;
                     wr_link    = rhead_ff;
                     rhead_in   = tail_ff;
                     rcnt_in    = rcnt_ff + CW'(1);
                     head_in    = '0;
                     tail_in    = '0;
                     len_in     = '0;
                  end else begin
                     cur_in    = head_ff;
                     k_in      = '0;
                     target_in = len_ff - CW'(2);
                     state_in  = S_WALK;
                  end
               end
               CMD_SEARCH: begin
                  if (len_ff == '0) begin
                     status_in = ST_NOTFOUND;
                  end else begin
                     cur_in    = head_ff;
                     k_in      = '0;
                     target_in = len_ff - CW'(1);
                     state_in  = S_WALK;
                  end
               end
               default: begin
               end
            endcase
         end
         S_ALLOC: begin
            node_in = alloc_node;
            if (rcnt_ff != '0) begin
               rhead_in = rd_link;
               rcnt_in  = rcnt_ff - CW'(1);
            end else begin
               fresh_in = fresh_ff + CW'(1);
            end
            if (is_front) begin
               wr_val_en  = 1'b1;
               wr_link_en = 1'b1;
               wr_addr    = alloc_node;
               wr_link    = (len_ff == '0) ? '0 : head_ff;
               head_in    = alloc_node;
               if (len_ff == '0) begin
                  tail_in = alloc_node;
               end
               len_in   = len_ff + CW'(1);
               state_in = S_RESP;
            end else if (is_back) begin
               wr_val_en  = 1'b1;
               wr_link_en = 1'b1;
               wr_addr    = alloc_node;
               tail_in    = alloc_node;
               len_in     = len_ff + CW'(1);
               if (len_ff == '0) begin
                  head_in  = alloc_node;
                  state_in = S_RESP;
               end else begin
                  cur_in   = tail_ff;
                  lnk_in   = alloc_node;
                  state_in = S_LINK;
               end
            end else begin
               cur_in    = head_ff;
               k_in      = '0;
               target_in = CW'(MW'(pos_ff) - MW'(1));
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            if (cmd_ff == CMD_SEARCH) begin
               if (rd_val == val_ff) begin
                  found_in = POS_BITS'(k_ff + CW'(1));
                  state_in = S_RESP;
               end else if (walk_end) begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_RESP;
               end
            end else if (walk_end) begin
               state_in = S_LINK;
               if (cmd_ff == CMD_INSERT_AT) begin
                  wr_val_en  = 1'b1;
                  wr_link_en = 1'b1;
                  wr_addr    = node_ff;
                  wr_link    = rd_link;
                  lnk_in     = node_ff;
                  len_in     = len_ff + CW'(1);
               end else begin
                  wr_link_en = 1'b1;
                  wr_addr    = tail_ff;
                  wr_link    = rhead_ff;
                  rhead_in   = tail_ff;
                  rcnt_in    = rcnt_ff + CW'(1);
                  tail_in    = cur_ff;
                  lnk_in     = '0;
                  len_in     = len_ff - CW'(1);
               end
            end
            if (!walk_end) begin
               rd_addr = rd_link;
               cur_in  = rd_link;
               k_in    = k_ff + CW'(1);
            end
         end
         S_POPF: begin
            wr_link_en = 1'b1;
            wr_addr    = head_ff;
            wr_link    = rhead_ff;
            rhead_in   = head_ff;
            rcnt_in    = rcnt_ff + CW'(1);
            len_in     = len_ff - CW'(1);
            if (len_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               head_in = rd_link;
            end
            state_in = S_RESP;
         end
         S_LINK: begin
            wr_link_en = 1'b1;
            wr_addr    = cur_ff;
            wr_link    = lnk_ff;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_length_in = POS_BITS'(len_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         fresh_ff     <= '0;
         rhead_ff     <= '0;
         rcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         fresh_ff     <= fresh_in;
         rhead_ff     <= rhead_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      node_ff       <= node_in;
      lnk_ff        <= lnk_in;
      k_ff          <= k_in;
      target_ff     <= target_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
   end

   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (fresh_ff == len_ff + rcnt_ff))
      else $error("node pool count mismatch");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (k_ff <= target_ff))
      else $error("walk ran past its target");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && (len_ff == '0)) |-> ((head_ff == '0) && (tail_ff == '0)))
      else $error("empty list with stale head or tail");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while a command is in progress");

endmodule

FILE: rtl/core/bll_ram.sv
module bll_ram
   import bll_pkg::*;
#(
   parameter int DEPTH     = CAPACITY_DEFAULT,
   parameter int WIDTH     = VALUE_BITS_DEFAULT,
   parameter int ADDR_BITS = $clog2(CAPACITY_DEFAULT)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/tb_bounded_linked_list_engine_unit.sv
module tb_bounded_linked_list_engine_unit
   import bll_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          POOL_SIZE   = CAPACITY_DEFAULT;
   localparam command_type CMD_UNUSED  = 3'd7;
   localparam int          IDLE_CHANCE = 16;

   typedef struct packed {
      status_type   status;
      position_type found;
      position_type length;
   } list_reply_type;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_type;

   logic clock;
   logic reset;

   bll_req_if req_ch();
   bll_rsp_if rsp_ch();

   bounded_linked_list_engine_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   data_type       list_image[$];
   list_reply_type awaited_replies[$];
   int             mismatch_count = 0;
   int             replies_seen   = 0;
   bit             steady_stream  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_bounded_linked_list_engine_unit failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR %0t reply %0d: %s", $time, replies_seen, what);
      mismatch_count++;
   endtask

   task automatic apply_to_list_image(input command_type cmd, input data_type value,
                                      input position_type position);
      list_reply_type r;
      r.status = ST_OK;
      r.found  = '0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (list_image.size() >= POOL_SIZE) r.status = ST_FULL;
            else list_image.insert(0, value);
         end
         CMD_PUSH_BACK: begin
            if (list_image.size() >= POOL_SIZE) r.status = ST_FULL;
            else list_image.insert(list_image.size(), value);
         end
         CMD_POP_FRONT: begin
            if (list_image.size() == 0) r.status = ST_EMPTY;
            else list_image.delete(0);
         end
         CMD_POP_BACK: begin
            if (list_image.size() == 0) r.status = ST_EMPTY;
            else list_image.delete(list_image.size() - 1);
         end
         CMD_INSERT_AT: begin
            if (int'(position) > list_image.size()) r.status = ST_BAD_POS;
            else if (list_image.size() >= POOL_SIZE) r.status = ST_FULL;
            else list_image.insert(int'(position), value);
         end
         CMD_SEARCH: begin
            r.status = ST_NOTFOUND;
            foreach (list_image[i]) begin
               if (r.status == ST_NOTFOUND && list_image[i] == value) begin
                  r.status = ST_OK;
                  r.found  = position_type'(i + 1);
               end
            end
         end
         default: ;
      endcase
      r.length = position_type'(list_image.size());
      awaited_replies.insert(awaited_replies.size(), r);
   endtask

   task automatic send_command(input command_type cmd, input data_type value,
                               input position_type position);
      bit accepted;
      while (!steady_stream && $urandom_range(99) < IDLE_CHANCE) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.command  <= cmd;
      req_ch.value    <= value;
      req_ch.position <= position;
      do begin
         @(negedge clock);
         accepted = req_ch.ready;
         @(posedge clock);
      end while (!accepted);
      apply_to_list_image(cmd, value, position);
   endtask

   task automatic wait_for_replies();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic check_reply(input status_type status, input position_type found,
                              input position_type length);
      list_reply_type want;
      replies_seen++;
      if (awaited_replies.size() == 0) begin
         report_mismatch($sformatf("unexpected reply status %0d length %0d", status, length));
         return;
      end
      want = awaited_replies[0];
      awaited_replies.delete(0);
      if (status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (found !== want.found)
         report_mismatch($sformatf("found_position %0d, expected %0d", found, want.found));
      if (length !== want.length)
         report_mismatch($sformatf("length %0d, expected %0d", length, want.length));
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready)
            check_reply(rsp_ch.status, rsp_ch.found_position, rsp_ch.length);
         @(posedge clock);
         rsp_ch.ready <= steady_stream || ($urandom_range(99) >= IDLE_CHANCE);
      end
   end

   function automatic data_type pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return data_type'($urandom_range(6)) - 32'sd3;
      if (roll < 60 && list_image.size() != 0)
         return list_image[$urandom_range(list_image.size() - 1)];
      if (roll < 70) begin
         case ($urandom_range(3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            default: return 32'shffff_ffff;
         endcase
      end
      return data_type'($urandom);
   endfunction

   function automatic position_type pick_position();
      int roll;
      int len;
      roll = $urandom_range(99);
      len  = list_image.size();
      if (roll < 75) return position_type'($urandom_range(len));
      if (roll < 85) return position_type'(len);
      if (roll < 95) return position_type'($urandom_range(127, len + 1));
      return position_type'($urandom_range(127));
   endfunction

   function automatic command_type pick_command(input traffic_mode_type mode);
      int roll;
      roll = $urandom_range(99);
      case (mode)
         MODE_GROW: begin
            if (roll < 30) return CMD_PUSH_FRONT;
            if (roll < 60) return CMD_PUSH_BACK;
            if (roll < 85) return CMD_INSERT_AT;
            if (roll < 92) return CMD_SEARCH;
            if (roll < 96) return CMD_LENGTH;
            if (roll < 98) return CMD_POP_FRONT;
            return CMD_POP_BACK;
         end
         MODE_SHRINK: begin
            if (roll < 30) return CMD_POP_FRONT;
            if (roll < 60) return CMD_POP_BACK;
            if (roll < 75) return CMD_SEARCH;
            if (roll < 85) return CMD_INSERT_AT;
            if (roll < 90) return CMD_PUSH_FRONT;
            if (roll < 95) return CMD_PUSH_BACK;
            if (roll < 98) return CMD_LENGTH;
            return CMD_UNUSED;
         end
         default: return command_type'($urandom_range(7));
      endcase
   endfunction

   task automatic send_random_item(input traffic_mode_type mode);
      send_command(pick_command(mode), pick_value(), pick_position());
   endtask

   task automatic test_empty_list();
      send_command(CMD_POP_FRONT, 32'sd0, 7'd0);
      send_command(CMD_POP_BACK, 32'sd0, 7'd0);
      send_command(CMD_SEARCH, 32'sd0, 7'd0);
      send_command(CMD_LENGTH, 32'sd0, 7'd0);
      send_command(CMD_INSERT_AT, 32'sd1, 7'd1);
      send_command(CMD_INSERT_AT, 32'sd1, 7'd127);
      send_command(CMD_UNUSED, 32'shffff_ffff, 7'd127);
   endtask

   task automatic test_short_list_edges();
      send_command(CMD_PUSH_BACK, 32'sh7fff_ffff, 7'd0);
      send_command(CMD_PUSH_BACK, 32'sh8000_0000, 7'd0);
      send_command(CMD_SEARCH, 32'sh8000_0000, 7'd0);
      send_command(CMD_POP_BACK, 32'sd0, 7'd0);
      send_command(CMD_POP_BACK, 32'sd0, 7'd0);
      send_command(CMD_INSERT_AT, 32'shffff_ffff, 7'd0);
      send_command(CMD_INSERT_AT, 32'sd0, 7'd1);
      send_command(CMD_INSERT_AT, 32'sd5, 7'd1);
      send_command(CMD_SEARCH, 32'sd5, 7'd0);
      send_command(CMD_PUSH_FRONT, 32'sd0, 7'd64);
      send_command(CMD_SEARCH, 32'sd0, 7'd0);
      send_command(CMD_SEARCH, 32'sd12345, 7'd0);
      send_command(CMD_POP_FRONT, 32'sd0, 7'd0);
      send_command(CMD_POP_FRONT, 32'sd0, 7'd0);
      send_command(CMD_POP_FRONT, 32'sd0, 7'd0);
      send_command(CMD_LENGTH, 32'sd0, 7'd0);
   endtask

   task automatic test_fill_and_drain();
      while (list_image.size() < POOL_SIZE) send_random_item(MODE_GROW);
      send_command(CMD_PUSH_FRONT, pick_value(), 7'd0);
      send_command(CMD_PUSH_BACK, pick_value(), 7'd0);
      send_command(CMD_INSERT_AT, pick_value(), 7'd30);
      send_command(CMD_INSERT_AT, pick_value(), 7'd64);
      send_command(CMD_INSERT_AT, pick_value(), 7'd65);
      send_command(CMD_SEARCH, list_image[POOL_SIZE - 1], 7'd0);
      send_command(CMD_SEARCH, pick_value(), 7'd0);
      while (list_image.size() > 0) send_random_item(MODE_SHRINK);
      send_command(CMD_POP_BACK, 32'sd0, 7'd0);
      send_command(CMD_POP_FRONT, 32'sd0, 7'd0);
   endtask

   task automatic test_steady_stream(input int count);
      steady_stream = 1'b1;
      repeat (count) send_random_item(MODE_MIXED);
      steady_stream = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      repeat (20) send_random_item(MODE_GROW);
      wait_for_replies();
      repeat (20) send_random_item(MODE_SHRINK);
   endtask

   task automatic test_random_traffic(input int count);
      traffic_mode_type mode;
      int               run;
      while (count > 0) begin
         case ($urandom_range(2))
            0:       mode = MODE_GROW;
            1:       mode = MODE_SHRINK;
            default: mode = MODE_MIXED;
         endcase
         run = $urandom_range(100, 20);
         if (run > count) run = count;
         repeat (run) send_random_item(mode);
         count -= run;
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.command  = CMD_LENGTH;
      req_ch.value    = '0;
      req_ch.position = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_short_list_edges();
      test_fill_and_drain();
      test_pause_until_drained();
      test_steady_stream(150);
      test_random_traffic(650);

      wait_for_replies();
      repeat (POOL_SIZE + 10) @(posedge clock);
      if (awaited_replies.size() != 0)
         report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));
      if (mismatch_count == 0) begin
         $display("tb_bounded_linked_list_engine_unit passed");
      end else begin
         $display("tb_bounded_linked_list_engine_unit failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/bll_pkg.sv
rtl/core/bll_req_if.sv
rtl/core/bll_rsp_if.sv
rtl/core/bll_ram.sv
rtl/core/bounded_linked_list_engine_unit.sv
test/tb_bounded_linked_list_engine_unit.sv
